// ===== src/hrfl_pkg.sv =====
// Shared constants, types and helpers for the hex record flash loader.
// No dependencies; the controller, datapath, top level and checker import this package.
package hrfl_pkg;

  localparam int FRAME_BYTES_DEF = 64;
  localparam int CFG_INDEX_W     = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_START = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_END   = 2'd1;

  localparam logic [31:0] WINDOW_START_RST = 32'h0030_0000;
  localparam logic [31:0] WINDOW_END_RST   = 32'h0033_FFFF;

  localparam logic [7:0] START_MARK = 8'h3A;
  localparam logic [7:0] TYPE_DATA  = 8'h00;
  localparam logic [7:0] TYPE_END   = 8'h01;
  localparam logic [7:0] TYPE_BASE  = 8'h04;
  localparam logic [7:0] TYPE_ERASE = 8'h10;

  localparam logic [2:0] KIND_PROGRAM  = 3'd0;
  localparam logic [2:0] KIND_ADDR_ERR = 3'd1;
  localparam logic [2:0] KIND_SUM_ERR  = 3'd2;
  localparam logic [2:0] KIND_BASE     = 3'd3;
  localparam logic [2:0] KIND_ERASE    = 3'd4;
  localparam logic [2:0] KIND_RESET    = 3'd5;
  localparam logic [2:0] KIND_EMPTY    = 3'd6;

  typedef struct packed {
    logic byte_fire;
    logic single_load;
    logic words_init;
    logic rd_step;
    logic hi_latch;
    logic word_load;
    logic out_fire;
  } hrfl_cmd_t;

  typedef struct packed {
    logic done_single;
    logic done_words;
    logic last_shown;
  } hrfl_sts_t;

  function automatic logic out_of_window(input logic [31:0] addr,
                                         input logic [31:0] lo,
                                         input logic [31:0] hi);
    return (addr > hi) || (addr < lo);
  endfunction

endpackage

// ===== src/hrfl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module hrfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/hrfl_ctrl.sv =====
// Controller of the loader: sequences byte reception, word readout and result beats.
// Depends on hrfl_pkg for the command and status structs.
module hrfl_ctrl
  import hrfl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  hrfl_sts_t sts,
  output hrfl_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_RECV  = 5'b00001,
    S_RD_HI = 5'b00010,
    S_RD_LO = 5'b00100,
    S_LOAD  = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd             = '0;
    cmd.byte_fire   = (state_r == S_RECV) && in_valid;
    cmd.single_load = cmd.byte_fire && sts.done_single;
    cmd.words_init  = cmd.byte_fire && sts.done_words;
    cmd.rd_step     = (state_r == S_RD_HI) || (state_r == S_RD_LO);
    cmd.hi_latch    = (state_r == S_RD_LO);
    cmd.word_load   = (state_r == S_LOAD);
    cmd.out_fire    = (state_r == S_OUT) && out_ready;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_RECV: begin
        if (cmd.single_load) begin
          state_nxt = S_OUT;
        end else if (cmd.words_init) begin
          state_nxt = S_RD_HI;
        end
      end
      S_RD_HI: state_nxt = S_RD_LO;
      S_RD_LO: state_nxt = S_LOAD;
      S_LOAD:  state_nxt = S_OUT;
      S_OUT: begin
        if (out_ready) begin
          state_nxt = sts.last_shown ? S_RECV : S_RD_HI;
        end
      end
      default: state_nxt = S_RECV;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RECV;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready  = (state_r == S_RECV);
  assign out_valid = (state_r == S_OUT);

endmodule

// ===== src/hrfl_dpath.sv =====
// Datapath of the loader: header capture, running checksum, frame store,
// record decision, window registers and the result register.
// Depends on hrfl_pkg and hrfl_ram.
module hrfl_dpath
  import hrfl_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [7:0]             in_rx_byte,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data,
  input  hrfl_cmd_t              cmd,
  output hrfl_sts_t              sts,
  output logic [2:0]             out_kind,
  output logic [31:0]            out_word_address,
  output logic [15:0]            out_data_word,
  output logic                   out_last
);

  localparam int IDX_W  = $clog2(FRAME_BYTES + 1);
  localparam int ADDR_W = $clog2(FRAME_BYTES);
  localparam int CMP_W  = (IDX_W > 9) ? IDX_W : 9;

  logic [IDX_W-1:0]  idx_r, idx_nxt, idx_inc;
  logic [7:0]        len_r, offh_r, offl_r, type_r, sum_r, b5_r, b6_r, hi_r;
  logic [15:0]       upper_r;
  logic [31:0]       win_start_r, win_end_r;
  logic [31:0]       waddr_r;
  logic [ADDR_W-1:0] rptr_r;
  logic [IDX_W-1:0]  wleft_r;
  logic [2:0]        kind_r;
  logic [31:0]       addr_r;
  logic [15:0]       data_r;
  logic              last_r;

  logic              at_start, in_head, at_type, in_body, type_ok, rec_done;
  logic [CMP_W-1:0]  need_len;
  logic [7:0]        sum_neg, base_hi, base_lo, rd_data;
  logic              sum_ok;
  logic [31:0]       start_addr, base_addr;
  logic [6:0]        words;
  logic              do_single, do_words, set_base;
  logic [2:0]        sgl_kind;
  logic [31:0]       sgl_addr;

  assign at_start = (idx_r == '0);
  assign in_head  = !at_start && (idx_r < IDX_W'(4));
  assign at_type  = (idx_r == IDX_W'(4));
  assign in_body  = (idx_r > IDX_W'(4));
  assign idx_inc  = idx_r + 1'b1;
  assign type_ok  = (in_rx_byte == TYPE_DATA) || (in_rx_byte == TYPE_END) ||
                    (in_rx_byte == TYPE_BASE) || (in_rx_byte == TYPE_ERASE);
  assign need_len = CMP_W'(len_r) + CMP_W'(6);
  assign rec_done = in_body && (need_len == CMP_W'(idx_inc));

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.byte_fire) begin
      priority if (at_start) begin
        if (in_rx_byte == START_MARK) idx_nxt = IDX_W'(1);
      end else if (in_head) begin
        idx_nxt = idx_inc;
      end else if (at_type) begin
        idx_nxt = type_ok ? IDX_W'(5) : '0;
      end else if (rec_done) begin
        idx_nxt = '0;
      end else if (idx_inc >= IDX_W'(FRAME_BYTES)) begin
        idx_nxt = '0;
      end else begin
        idx_nxt = idx_inc;
      end
    end
  end

  assign sum_neg    = ~sum_r + 8'd1;
  assign sum_ok     = (sum_neg == in_rx_byte);
  assign start_addr = {upper_r, offh_r, offl_r};
  assign base_hi    = (len_r >= 8'd1) ? b5_r : 8'd0;
  assign base_lo    = (len_r >= 8'd2) ? b6_r : 8'd0;
  assign base_addr  = {base_hi, base_lo, 16'h0000};
  assign words      = len_r[7:1];

  always_comb begin
    do_single = 1'b0;
    do_words  = 1'b0;
    set_base  = 1'b0;
    sgl_kind  = KIND_SUM_ERR;
    sgl_addr  = '0;
    if (!sum_ok) begin
      do_single = 1'b1;
    end else begin
      unique case (type_r)
        TYPE_DATA: begin
          if (out_of_window(start_addr, win_start_r, win_end_r)) begin
            do_single = 1'b1;
            sgl_kind  = KIND_ADDR_ERR;
            sgl_addr  = start_addr;
          end else if (words == '0) begin
            do_single = 1'b1;
            sgl_kind  = KIND_EMPTY;
          end else begin
            do_words = 1'b1;
          end
        end
        TYPE_BASE: begin
          do_single = 1'b1;
          set_base  = 1'b1;
          sgl_addr  = base_addr;
          sgl_kind  = out_of_window(base_addr, win_start_r, win_end_r) ?
                      KIND_ADDR_ERR : KIND_BASE;
        end
        TYPE_END: begin
          do_single = 1'b1;
          sgl_kind  = KIND_RESET;
        end
        TYPE_ERASE: begin
          do_single = 1'b1;
          sgl_kind  = KIND_ERASE;
        end
        default: begin
          do_single = 1'b0;
        end
      endcase
    end
  end

  assign sts.done_single = rec_done && do_single;
  assign sts.done_words  = rec_done && do_words;
  assign sts.last_shown  = last_r;

  hrfl_ram #(
    .WIDTH(8),
    .DEPTH(FRAME_BYTES)
  ) u_store (
    .clk    (clk),
    .wr_en  (cmd.byte_fire && in_body),
    .wr_addr(idx_r[ADDR_W-1:0]),
    .wr_data(in_rx_byte),
    .rd_addr(rptr_r),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      upper_r     <= '0;
      win_start_r <= WINDOW_START_RST;
      win_end_r   <= WINDOW_END_RST;
    end else begin
      idx_r <= idx_nxt;
      if (cmd.single_load && set_base) begin
        upper_r <= {base_hi, base_lo};
      end
      if (cfg_we) begin
        priority if (cfg_index == CFG_WINDOW_START) begin
          win_start_r <= cfg_data;
        end else if (cfg_index == CFG_WINDOW_END) begin
          win_end_r <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_fire) begin
      if (at_start) begin
        sum_r <= '0;
      end else begin
        sum_r <= sum_r + in_rx_byte;
      end
      if (idx_r == IDX_W'(1)) len_r  <= in_rx_byte;
      if (idx_r == IDX_W'(2)) offh_r <= in_rx_byte;
      if (idx_r == IDX_W'(3)) offl_r <= in_rx_byte;
      if (at_type)            type_r <= in_rx_byte;
      if (idx_r == IDX_W'(5)) b5_r   <= in_rx_byte;
      if (idx_r == IDX_W'(6)) b6_r   <= in_rx_byte;
    end
    if (cmd.words_init) begin
      waddr_r <= start_addr;
      rptr_r  <= ADDR_W'(5);
      wleft_r <= IDX_W'(words);
    end else begin
      if (cmd.rd_step) rptr_r <= rptr_r + 1'b1;
      if (cmd.out_fire) begin
        waddr_r <= waddr_r + 32'd1;
        wleft_r <= wleft_r - 1'b1;
      end
    end
    if (cmd.hi_latch) hi_r <= rd_data;
    if (cmd.single_load) begin
      kind_r <= sgl_kind;
      addr_r <= sgl_addr;
      data_r <= '0;
      last_r <= 1'b1;
    end else if (cmd.word_load) begin
      kind_r <= KIND_PROGRAM;
      addr_r <= waddr_r;
      data_r <= {hi_r, rd_data};
      last_r <= (wleft_r == IDX_W'(1));
    end
  end

  assign out_kind         = kind_r;
  assign out_word_address = addr_r;
  assign out_data_word    = data_r;
  assign out_last         = last_r;

endmodule

// ===== src/hex_record_flash_loader_unit.sv =====
// Hex record flash loader: top level joining controller and datapath; depends on hrfl_pkg.
// A checksum error, address error, base, erase, reset or empty-data result shows the
// cycle after the checksum beat. Data records step through the read-high, read-low and
// load states before each word beat, and go back to read-high after each taken beat
// that is not the last; input is held off until the last result beat is taken.
// Reset: synchronous, active low; clears reception and upper address, loads window defaults.
module hex_record_flash_loader_unit
  import hrfl_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_rx_byte,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [2:0]             out_kind,
  output logic [31:0]            out_word_address,
  output logic [15:0]            out_data_word,
  output logic                   out_last,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data
);

  hrfl_cmd_t cmd;
  hrfl_sts_t sts;

  hrfl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hrfl_dpath #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_rx_byte      (in_rx_byte),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cmd             (cmd),
    .sts             (sts),
    .out_kind        (out_kind),
    .out_word_address(out_word_address),
    .out_data_word   (out_data_word),
    .out_last        (out_last)
  );

endmodule

// ===== src/hrfl_checker.sv =====
// Port-level checks for the hex record flash loader, bound to the top level.
// Depends on hrfl_pkg for the result kind codes.
module hrfl_port_checks
  import hrfl_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [31:0] out_word_address,
  input logic [15:0] out_data_word,
  input logic        out_last
);

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result beat is pending");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
    $stable(out_word_address) && $stable(out_data_word) && $stable(out_last))
    else $error("stalled result beat changed");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_PROGRAM) |-> out_last)
    else $error("non-word result without last");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_PROGRAM) && (out_kind != KIND_BASE) &&
    (out_kind != KIND_ADDR_ERR) |-> (out_word_address == '0) && (out_data_word == '0))
    else $error("status result carries nonzero fields");

  a_resume: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> in_ready && !out_valid)
    else $error("reception did not resume after last beat");

endmodule

bind hex_record_flash_loader_unit hrfl_port_checks u_hrfl_port_checks (.*);
